>>> rtl/core/pngu_pkg.sv
// Shared constants, codes and pixel arithmetic for the PNG scanline unfilter.
// No dependencies; imported by the interfaces and every module of the block.
`timescale 1ns / 1ps

package pngu_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WIDTH_W    = 11;
  localparam int ROW_W      = 16;
  localparam int BYTE_W     = 8;
  localparam int PIX_W      = 3 * BYTE_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

  // Byte position within a pixel
  localparam logic [1:0] PH_FILTER = 2'd0;
  localparam logic [1:0] PH_RED    = 2'd1;
  localparam logic [1:0] PH_GREEN  = 2'd2;
  localparam logic [1:0] PH_BLUE   = 2'd3;

  // Row filter codes
  localparam logic [BYTE_W-1:0] FILT_NONE = 8'd0;
  localparam logic [BYTE_W-1:0] FILT_SUB  = 8'd1;
  localparam logic [BYTE_W-1:0] FILT_UP   = 8'd2;

  typedef logic [PIX_W-1:0] pixel_t;

  // Bytewise add modulo 256 of two packed RGB pixels
  function automatic pixel_t add_pixels(input pixel_t a, input pixel_t b);
    pixel_t sum;
    for (int i = 0; i < 3; i++) begin
      sum[i*BYTE_W +: BYTE_W] = a[i*BYTE_W +: BYTE_W] + b[i*BYTE_W +: BYTE_W];
    end
    return sum;
  endfunction

endpackage

>>> rtl/core/pngu_if.sv
// Valid/ready channels of the PNG unfilter: filtered byte stream in, pixels out.
// Depends on pngu_pkg for field widths.
`timescale 1ns / 1ps

interface pngu_byte_if import pngu_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface pngu_pixel_if import pngu_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] red;
  logic [BYTE_W-1:0] green;
  logic [BYTE_W-1:0] blue;
  logic [COL_W-1:0]  pixel_x;
  logic [ROW_W-1:0]  pixel_y;
  logic              unsupported_filter;
  logic              last_pixel;

  modport source (output valid, output red, output green, output blue, output pixel_x,
                  output pixel_y, output unsupported_filter, output last_pixel,
                  input ready);
  modport sink   (input valid, input red, input green, input blue, input pixel_x,
                  input pixel_y, input unsupported_filter, input last_pixel,
                  output ready);
endinterface

>>> rtl/core/pngu_line_buf.sv
// Previous-row line store: one RGB pixel per column, one write and one read port.
// Depends on pngu_pkg. Read data is registered.
`timescale 1ns / 1ps

module pngu_line_buf import pngu_pkg::*; (
  input  logic             clk,
  input  logic             we,
  input  logic [COL_W-1:0] waddr,
  input  pixel_t           wdata,
  input  logic [COL_W-1:0] raddr,
  output pixel_t           rdata
);

  pixel_t mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/png_scanline_unfilter_rgb8.sv
// PNG scanline unfilter for 8-bit RGB: takes one stream byte per unstalled cycle and
// emits one reconstructed pixel per blue byte. Depends on pngu_pkg, pngu_if, pngu_line_buf.
`timescale 1ns / 1ps

// Accepts one byte every cycle while not stalled; a pixel is loaded into the output
// register when its blue byte is transferred, and the input keeps taking bytes
// while that pixel waits as long as the output register is free or being
// drained. The line store read for a column is started while its red and green
// bytes arrive, so the Up predictor is ready when blue comes; the store needs no
// clearing pass after reset, and an image must not read a column of the row
// above that was never written. Filters None, Sub and Up are reconstructed;
// any other code passes bytes through with unsupported_filter set.
// Configuration must be written only while the block is idle; it is not enforced.
module png_scanline_unfilter_rgb8 import pngu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  pngu_byte_if.sink             stream,
  pngu_pixel_if.source          pixel
);

  logic [WIDTH_W-1:0] image_width;
  logic [ROW_W-1:0]   image_height;

  logic [1:0]         phase;
  logic [COL_W-1:0]   column_count;
  logic [ROW_W-1:0]   row_count;
  logic [BYTE_W-1:0]  row_filter;
  logic [BYTE_W-1:0]  held_red;
  logic [BYTE_W-1:0]  held_green;
  pixel_t             left_pixel;
  pixel_t             above_pixel;

  logic               in_fire;
  logic               pix_fire;
  logic [WIDTH_W-1:0] eff_width;
  logic [ROW_W-1:0]   eff_height;
  logic [WIDTH_W-1:0] col_plus;
  logic [ROW_W:0]     row_plus;
  logic               row_end;
  logic               last;
  logic               flag;
  pixel_t             pred;
  pixel_t             pix_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_W'(1);
      image_height <= ROW_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  assign stream.ready = !pixel.valid || pixel.ready;
  assign in_fire      = stream.valid && stream.ready;
  assign pix_fire     = in_fire && (phase == PH_BLUE);

  always_comb begin
    if (image_width == '0) begin
      eff_width = WIDTH_W'(1);
    end else if (image_width > WIDTH_W'(MAX_WIDTH)) begin
      eff_width = WIDTH_W'(MAX_WIDTH);
    end else begin
      eff_width = image_width;
    end
    eff_height = (image_height == '0) ? ROW_W'(1) : image_height;
  end

  assign col_plus = WIDTH_W'(column_count) + WIDTH_W'(1);
  assign row_plus = {1'b0, row_count} + (ROW_W+1)'(1);
  assign row_end  = col_plus >= eff_width;
  assign last     = row_end && (row_plus >= {1'b0, eff_height});

  always_comb begin
    pred = '0;
    flag = 1'b0;
    case (row_filter)
      FILT_NONE: ;
      FILT_SUB:  pred = (column_count != '0) ? left_pixel : '0;
      FILT_UP:   pred = (row_count != '0) ? above_pixel : '0;
      default:   flag = 1'b1;
    endcase
    pix_next = add_pixels({held_red, held_green, stream.data_byte}, pred);
  end

  // Byte sequencing and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_FILTER;
      column_count <= '0;
      row_count    <= '0;
      row_filter   <= '0;
      held_red     <= '0;
      held_green   <= '0;
      left_pixel   <= '0;
    end else if (in_fire) begin
      unique case (phase)
        PH_FILTER: begin
          row_filter <= stream.data_byte;
          phase      <= PH_RED;
        end
        PH_RED: begin
          held_red <= stream.data_byte;
          phase    <= PH_GREEN;
        end
        PH_GREEN: begin
          held_green <= stream.data_byte;
          phase      <= PH_BLUE;
        end
        PH_BLUE: begin
          if (row_end) begin
            column_count <= '0;
            left_pixel   <= '0;
            phase        <= PH_FILTER;
            row_count    <= last ? '0 : row_plus[ROW_W-1:0];
          end else begin
            column_count <= col_plus[COL_W-1:0];
            left_pixel   <= pix_next;
            phase        <= PH_RED;
          end
        end
        default: phase <= PH_FILTER;
      endcase
    end
  end

  // Column address is stable from the red byte on, so the read has settled by blue
  pngu_line_buf u_line_buf (
    .clk   (clk),
    .we    (pix_fire),
    .waddr (column_count),
    .wdata (pix_next),
    .raddr (column_count),
    .rdata (above_pixel)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel.valid <= 1'b0;
    end else if (pix_fire) begin
      pixel.valid <= 1'b1;
    end else if (pixel.ready) begin
      pixel.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_fire) begin
      pixel.red                <= pix_next[2*BYTE_W +: BYTE_W];
      pixel.green              <= pix_next[BYTE_W +: BYTE_W];
      pixel.blue               <= pix_next[0 +: BYTE_W];
      pixel.pixel_x            <= column_count;
      pixel.pixel_y            <= row_count;
      pixel.unsupported_filter <= flag;
      pixel.last_pixel         <= last;
    end
  end

`ifndef NO_ASSERTIONS
  a_blue_makes_pixel: assert property (@(posedge clk) disable iff (rst)
    pix_fire |=> pixel.valid)
    else $error("blue byte transfer did not load a pixel");

  a_filter_at_col0: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_FILTER) |-> (column_count == '0))
    else $error("filter byte expected away from column zero");

  a_left_clear_col0: assert property (@(posedge clk) disable iff (rst)
    (column_count == '0) |-> (left_pixel == '0))
    else $error("left pixel not cleared at row start");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (pixel.valid && !pixel.ready) |-> !stream.ready)
    else $error("input taken while output register is held");
`endif

endmodule
